// ===== hdl/fpba_pkg.sv =====
// Shared types and codes for the fit-policy block allocator.
// No dependencies; used by fpba_table, fpba_ctrl and the top level.
package fpba_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic REG_FIT_POLICY    = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam logic [5:0] BLOCKS_IN_USE_RST = 6'd32;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

// ===== hdl/fpba_table.sv =====
// Free-size table: one write port, one read port, registered read data.
// Depends on fpba_pkg for the port control struct.
module fpba_table #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 16
) (
  input  logic                 clk,
  input  fpba_pkg::tbl_ctl_t   ctl,
  input  logic [AW-1:0]        waddr,
  input  logic [DW-1:0]        wdata,
  input  logic [AW-1:0]        raddr,
  output logic [DW-1:0]        rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/fpba_ctrl.sv =====
// Sequencer: takes loads and requests, scans the table one entry per cycle,
// writes back the chosen entry and holds the result register.
// Depends on fpba_pkg; drives fpba_table.
module fpba_ctrl #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [4:0]            in_index,
  input  logic [15:0]           in_size,
  input  logic [1:0]            fit_policy,
  input  logic [CNT_W-1:0]      n_active,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_granted,
  output logic [4:0]            out_block,
  output logic [15:0]           out_size,
  output fpba_pkg::tbl_ctl_t    tbl_ctl,
  output logic [IDX_W-1:0]      tbl_waddr,
  output logic [SIZE_BITS-1:0]  tbl_wdata,
  output logic [IDX_W-1:0]      tbl_raddr,
  input  logic [SIZE_BITS-1:0]  tbl_rdata
);

  fpba_pkg::state_t state;
  fpba_pkg::state_t state_next;

  logic [SIZE_BITS-1:0] req_size;
  logic [1:0]           policy;
  logic [CNT_W-1:0]     n_scan;
  logic [CNT_W-1:0]     cnt;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic                 res_granted;
  logic [4:0]           res_block;
  logic [SIZE_BITS-1:0] res_size;

  logic                 accept;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] in_size_m;
  logic                 issue;
  logic                 fits;
  logic                 take;
  logic                 scan_end;
  logic                 out_free;
  logic [SIZE_BITS-1:0] left;

  assign in_ready  = (state == fpba_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_size_m = SIZE_BITS'(in_size);
  assign load_ok   = (32'(in_index) < NUM_BLOCKS);
  assign issue     = (state == fpba_pkg::ST_SCAN) && (cnt < n_scan);
  assign scan_end  = (state == fpba_pkg::ST_SCAN) && (cnt == n_scan) && !rd_valid;
  assign fits      = (tbl_rdata >= req_size);
  assign take      = rd_valid && fits &&
                     (!found ||
                      ((policy == fpba_pkg::POL_BEST)  && (tbl_rdata < best_size)) ||
                      ((policy == fpba_pkg::POL_WORST) && (tbl_rdata > best_size)));
  assign out_free  = !out_valid || out_ready;
  assign left      = best_size - req_size;
  assign tbl_raddr = cnt[IDX_W-1:0];

  always_comb begin
    tbl_ctl.rd_en = issue;
    tbl_ctl.wr_en = 1'b0;
    tbl_waddr     = best_idx;
    tbl_wdata     = left;
    if (state == fpba_pkg::ST_WRITE) begin
      tbl_ctl.wr_en = 1'b1;
    end else if (accept && (in_mode == fpba_pkg::MODE_LOAD)) begin
      tbl_ctl.wr_en = load_ok;
      tbl_waddr     = IDX_W'(in_index);
      tbl_wdata     = in_size_m;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpba_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_mode == fpba_pkg::MODE_REQUEST) ? fpba_pkg::ST_SCAN
                                                           : fpba_pkg::ST_DONE;
        end
      end
      fpba_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = found ? fpba_pkg::ST_WRITE : fpba_pkg::ST_DONE;
        end
      end
      fpba_pkg::ST_WRITE: state_next = fpba_pkg::ST_DONE;
      fpba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = fpba_pkg::ST_IDLE;
        end
      end
      default: state_next = fpba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpba_pkg::ST_IDLE;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (accept) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if ((state == fpba_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_size <= in_size_m;
      policy   <= fit_policy;
      n_scan   <= n_active;
      cnt      <= '0;
      // load result is known at once
      res_granted <= 1'b0;
      res_block   <= in_index;
      res_size    <= load_ok ? in_size_m : '0;
    end
    if (issue) begin
      cnt <= cnt + 1'b1;
    end
    rd_idx <= cnt[IDX_W-1:0];
    if (take) begin
      best_idx  <= rd_idx;
      best_size <= tbl_rdata;
    end
    if (scan_end && !found) begin
      res_granted <= 1'b0;
      res_block   <= '0;
      res_size    <= '0;
    end
    if (state == fpba_pkg::ST_WRITE) begin
      res_granted <= 1'b1;
      res_block   <= 5'(best_idx);
      res_size    <= left;
    end
    if ((state == fpba_pkg::ST_DONE) && out_free) begin
      out_granted <= res_granted;
      out_block   <= res_block;
      out_size    <= 16'(res_size);
    end
  end

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (CNT_W'(rd_idx) < n_scan))
    else $error("table read beyond scanned range");

  a_write_found: assert property (@(posedge clk) disable iff (rst)
    (state == fpba_pkg::ST_WRITE) |-> found)
    else $error("write-back without a fitting block");

  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    (state == fpba_pkg::ST_WRITE) |-> (best_size >= req_size))
    else $error("chosen block smaller than request");

  a_req_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_mode == fpba_pkg::MODE_REQUEST)) |=> (state == fpba_pkg::ST_SCAN))
    else $error("request did not start a scan");

endmodule

// ===== hdl/fit_policy_block_allocator_top.sv =====
// Fit-policy block allocator: a table of block free sizes searched by first,
// best or worst fit. A load writes its table entry and goes straight to its
// result; a request scans the first blocks_in_use entries (at most the table
// depth) through the single table read port, one entry per cycle, then waits
// for the last read data and, on a grant, writes the remainder back before
// its result. Entries must be loaded before a request scans them.
// One item is in flight at a time; the result register lets the next item
// be taken while a result waits. Depends on fpba_pkg, fpba_table, fpba_ctrl.
module fit_policy_block_allocator_top #(
  parameter int NUM_BLOCKS = 32,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [4:0] block_index, [20:5] size_value, rest zero
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] chosen_block, [20:5] size_left, rest zero
  output logic        m_tuser,   // granted
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [1:0]           fit_policy;
  logic [5:0]           blocks_in_use;
  logic [CNT_W-1:0]     n_active;
  logic [4:0]           out_block;
  logic [15:0]          out_size;
  fpba_pkg::tbl_ctl_t   tbl_ctl;
  logic [IDX_W-1:0]     tbl_waddr;
  logic [SIZE_BITS-1:0] tbl_wdata;
  logic [IDX_W-1:0]     tbl_raddr;
  logic [SIZE_BITS-1:0] tbl_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= fpba_pkg::POL_FIRST;
      blocks_in_use <= fpba_pkg::BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpba_pkg::REG_FIT_POLICY:    fit_policy    <= cfg_data[1:0];
        fpba_pkg::REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate to the table depth
  always_comb begin
    if (32'(blocks_in_use) > NUM_BLOCKS) begin
      n_active = CNT_W'(NUM_BLOCKS);
    end else begin
      n_active = CNT_W'(blocks_in_use);
    end
  end

  assign m_tdata = {3'b000, out_size, out_block};

  fpba_table #(
    .DEPTH (NUM_BLOCKS),
    .AW    (IDX_W),
    .DW    (SIZE_BITS)
  ) u_table (
    .clk   (clk),
    .ctl   (tbl_ctl),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  fpba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_index    (s_tdata[4:0]),
    .in_size     (s_tdata[20:5]),
    .fit_policy  (fit_policy),
    .n_active    (n_active),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_granted (m_tuser),
    .out_block   (out_block),
    .out_size    (out_size),
    .tbl_ctl     (tbl_ctl),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (tbl_rdata)
  );

endmodule
